// ===== hw/rtl/lmbs_pkg.sv =====
package lmbs_pkg;

   localparam int MaxNodes   = 1024;
   localparam int MaxLayers  = 8;
   localparam int WordBits   = 64;
   localparam int Wpl        = MaxNodes / WordBits;
   localparam int Depth      = MaxLayers * Wpl;
   localparam int AddrW      = $clog2(Depth);
   localparam int WordIdxW   = $clog2(Wpl);
   localparam int LayerW     = 3;

   localparam logic [3:0] CMD_QUERY  = 4'd0;
   localparam logic [3:0] CMD_MARK   = 4'd1;
   localparam logic [3:0] CMD_UNMARK = 4'd2;
   localparam logic [3:0] CMD_INVERT = 4'd3;
   localparam logic [3:0] CMD_ALLOC  = 4'd4;
   localparam logic [3:0] CMD_FREE   = 4'd5;
   localparam logic [3:0] CMD_CLEAR  = 4'd6;
   localparam logic [3:0] CMD_COUNT  = 4'd7;
   localparam logic [3:0] CMD_MERGE  = 4'd8;
   localparam logic [3:0] CMD_UCOUNT = 4'd9;
   localparam logic [3:0] CMD_WUSED  = 4'd10;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_LAYER = 2'd1;
   localparam logic [1:0] ST_NO_FREE   = 2'd2;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

   localparam logic [0:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [0:0] CSR_INIT_LAYERS = 1'b1;

   typedef struct packed {
      logic [3:0] cmd;
      logic [9:0] node;
      logic [2:0] layer;
      logic [2:0] src_layer;
      logic [7:0] used_mask_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        marked;
      logic [2:0]  new_layer;
      logic [10:0] mark_count;
      logic [7:0]  used_mask;
      logic [3:0]  used_count;
   } rsp_type;

endpackage

// ===== hw/rtl/layered_mark_bitmap_store.sv =====
// Layered mark bitmap store. Each command is one transaction on req_ and yields
// exactly one transaction on rsp_. The marks live in a 128 x 64 single-port-write,
// registered-read RAM; one shared word unit (read, modify, write back) walks it.
// Steps from the accepting edge until rsp_valid rises:
// alloc from the free mask, write used, used count and unknown commands
// need only the decode and the response. Query, mark and unmark pass through
// the decode, the RAM read wait, the write back and the response. Clear, free
// and a growing alloc write one word per cycle over all 16 words of the layer.
// Invert and count take a read wait and a write step for each word; count
// only sums the word there and writes nothing. Or-merge takes a source read,
// a destination read, a read wait and a write for each destination word. The
// block takes no new request until the previous response transaction has been
// accepted, so a stalled receiver stalls the input. After reset and after any
// CSR write it clears all 128 RAM words, one a cycle, before taking a request.
// A node at or above node_count reads as unmarked and is never changed.
module layered_mark_bitmap_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lmbs_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lmbs_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [10:0]          csr_data
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_RD    = 7'b0000100,
      S_RD2   = 7'b0001000,
      S_WAIT  = 7'b0010000,
      S_WR    = 7'b0100000,
      S_RSP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [lmbs_pkg::AddrW-1:0]    init_ptr_ff, init_ptr_in;
   logic [lmbs_pkg::WordIdxW:0]   wcnt_ff, wcnt_in;
   logic [10:0]                   node_count_ff, node_count_in;
   logic [3:0]                    init_layers_ff, init_layers_in;
   logic [7:0]                    mask_ff, mask_in;
   logic [3:0]                    present_ff, present_in;
   lmbs_pkg::req_type             req_ff, req_in;
   lmbs_pkg::rsp_type             rsp_ff, rsp_in;
   logic [2:0]                    tgt_ff, tgt_in;
   logic [10:0]                   count_ff, count_in;
   logic [63:0]                   src_word_ff, src_word_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          wr_en;
   logic [lmbs_pkg::AddrW-1:0]    wr_addr, rd_addr;
   logic [63:0]                   wr_data, rd_data;

   lmbs_ram #(.Width(64), .Depth(lmbs_pkg::Depth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Helpers on the current word.
   logic [lmbs_pkg::WordIdxW-1:0] widx;
   logic [10:0]                   eff_nodes;
   logic [10:0]                   base;
   logic [63:0]                   valid_bits;
   logic [6:0]                    pop;
   logic [7:0]                    present_mask;
   logic                          whole;
   logic [7:0]                    free_bits;
   logic [2:0]                    low_free;
   logic                          lay_ok, src_ok, node_ok;
   logic [6:0]                    tail;

   assign widx       = wcnt_ff[lmbs_pkg::WordIdxW-1:0];
   assign eff_nodes  = (node_count_ff > 11'(lmbs_pkg::MaxNodes)) ?
                       11'(lmbs_pkg::MaxNodes) : node_count_ff;
   assign base       = {1'b0, widx, 6'b0};
   assign present_mask = 8'((9'd1 << present_ff) - 9'd1);
   assign free_bits  = present_mask & ~mask_ff;
   assign lay_ok     = {1'b0, req_ff.layer} < present_ff;
   assign src_ok     = {1'b0, req_ff.src_layer} < present_ff;
   assign node_ok    = {1'b0, req_ff.node} < eff_nodes;
   assign tail       = 7'(eff_nodes - base);
   assign whole      = (eff_nodes > base) && ((eff_nodes - base) >= 11'd64);

   always_comb begin
      if (eff_nodes <= base) begin
         valid_bits = '0;
      end else if (whole) begin
         valid_bits = '1;
      end else begin
         valid_bits = (64'd1 << tail[5:0]) - 64'd1;
      end
   end

   always_comb begin
      pop = '0;
      for (int i = 0; i < 64; i++) begin
         pop = pop + 7'(rd_data[i]);
      end
   end

   always_comb begin
      low_free = '0;
      for (int i = 7; i >= 0; i--) begin
         if (free_bits[i]) begin
            low_free = 3'(i);
         end
      end
   end

   // Kind of work the request needs.
   logic is_bit;
   always_comb begin
      is_bit  = (req_ff.cmd == lmbs_pkg::CMD_QUERY) || (req_ff.cmd == lmbs_pkg::CMD_MARK) ||
                (req_ff.cmd == lmbs_pkg::CMD_UNMARK);
   end

   logic [5:0] bitpos;
   assign bitpos = req_ff.node[5:0];

   always_comb begin
      state_in       = state_ff;
      init_ptr_in    = init_ptr_ff;
      wcnt_in        = wcnt_ff;
      node_count_in  = node_count_ff;
      init_layers_in = init_layers_ff;
      mask_in        = mask_ff;
      present_in     = present_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      tgt_in         = tgt_ff;
      count_in       = count_ff;
      src_word_in    = src_word_ff;
      rsp_valid_in   = rsp_valid_ff;
      wr_en          = 1'b0;
      wr_addr        = {tgt_ff, widx};
      wr_data        = '0;
      rd_addr        = {tgt_ff, widx};

      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ptr_ff;
            init_ptr_in = init_ptr_ff + 1'b1;
            if (init_ptr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == lmbs_pkg::CSR_NODE_COUNT) begin
                  node_count_in = csr_data;
               end else begin
                  init_layers_in = csr_data[3:0];
               end
               state_in    = S_INIT;
               init_ptr_in = '0;
            end else if (req_valid && !rsp_valid_ff) begin
               req_in   = req_data;
               tgt_in   = req_data.layer;
               count_in = '0;
               wcnt_in  = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // Decide the command, checks and first read.
            rsp_in = '0;
            if (is_bit) begin
               if (!lay_ok) begin
                  rsp_in.status = lmbs_pkg::ST_BAD_LAYER;
                  state_in = S_RSP;
               end else begin
                  rd_addr = {tgt_ff, req_ff.node[9:6]};
                  wcnt_in = {1'b0, req_ff.node[9:6]};
                  state_in = S_WAIT;
               end
            end else if (req_ff.cmd == lmbs_pkg::CMD_ALLOC) begin
               if (free_bits != '0) begin
                  rsp_in.new_layer = low_free;
                  mask_in = mask_ff | (8'd1 << low_free);
                  state_in = S_RSP;
               end else if (present_ff >= 4'(lmbs_pkg::MaxLayers)) begin
                  rsp_in.status = lmbs_pkg::ST_NO_FREE;
                  state_in = S_RSP;
               end else begin
                  rsp_in.new_layer = present_ff[2:0];
                  tgt_in   = present_ff[2:0];
                  mask_in  = mask_ff | (8'd1 << present_ff[2:0]);
                  present_in = present_ff + 4'd1;
                  state_in = S_WR;
               end
            end else if (req_ff.cmd == lmbs_pkg::CMD_FREE) begin
               if (!lay_ok) begin
                  rsp_in.status = lmbs_pkg::ST_BAD_LAYER;
                  state_in = S_RSP;
               end else if (!mask_ff[req_ff.layer]) begin
                  rsp_in.status = lmbs_pkg::ST_NOT_ALLOC;
                  state_in = S_RSP;
               end else begin
                  mask_in = mask_ff & ~(8'd1 << req_ff.layer);
                  state_in = S_WR;
               end
            end else if (req_ff.cmd == lmbs_pkg::CMD_CLEAR) begin
               if (!lay_ok) begin
                  rsp_in.status = lmbs_pkg::ST_BAD_LAYER;
                  state_in = S_RSP;
               end else begin
                  state_in = S_WR;
               end
            end else if (req_ff.cmd == lmbs_pkg::CMD_MERGE) begin
               if (!lay_ok || !src_ok) begin
                  rsp_in.status = lmbs_pkg::ST_BAD_LAYER;
                  state_in = S_RSP;
               end else begin
                  rd_addr  = {req_ff.src_layer, widx};
                  state_in = S_RD2;
               end
            end else if ((req_ff.cmd == lmbs_pkg::CMD_INVERT) ||
                         (req_ff.cmd == lmbs_pkg::CMD_COUNT)) begin
               if (!lay_ok) begin
                  rsp_in.status = lmbs_pkg::ST_BAD_LAYER;
                  state_in = S_RSP;
               end else begin
                  state_in = S_WAIT;
               end
            end else begin
               if (req_ff.cmd == lmbs_pkg::CMD_WUSED) begin
                  mask_in = req_ff.used_mask_in & present_mask;
               end
               state_in = S_RSP;
            end
         end
         S_RD2: begin
            // The source word arrives now; keep it and read the destination word.
            src_word_in = rd_data;
            rd_addr     = {tgt_ff, widx};
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_WR;
         end
         S_WR: begin
            if (is_bit) begin
               wr_addr = {tgt_ff, req_ff.node[9:6]};
               wr_data = rd_data;
               if (req_ff.cmd == lmbs_pkg::CMD_QUERY) begin
                  rsp_in.marked = node_ok & rd_data[bitpos];
               end else if (node_ok) begin
                  wr_en = 1'b1;
                  wr_data[bitpos] = (req_ff.cmd == lmbs_pkg::CMD_MARK);
               end
               state_in = S_RSP;
            end else begin
               case (req_ff.cmd)
                  lmbs_pkg::CMD_INVERT: begin
                     wr_en = 1'b1;
                     wr_data = ~rd_data & valid_bits;
                  end
                  lmbs_pkg::CMD_COUNT: begin
                     count_in = count_ff + 11'(pop);
                  end
                  lmbs_pkg::CMD_MERGE: begin
                     wr_en = 1'b1;
                     wr_data = rd_data | src_word_ff;
                  end
                  default: begin
                     wr_en = 1'b1;
                     wr_data = '0;
                  end
               endcase
               wcnt_in = wcnt_ff + 1'b1;
               if (widx == '1) begin
                  rsp_in.mark_count = (req_ff.cmd == lmbs_pkg::CMD_COUNT) ?
                                      count_ff + 11'(pop) : 11'd0;
                  state_in = S_RSP;
               end else if ((req_ff.cmd == lmbs_pkg::CMD_INVERT) ||
                            (req_ff.cmd == lmbs_pkg::CMD_COUNT)) begin
                  rd_addr  = {tgt_ff, widx + 1'b1};
                  state_in = S_WAIT;
               end else if (req_ff.cmd == lmbs_pkg::CMD_MERGE) begin
                  state_in = S_RD;
               end
            end
         end
         S_RSP: begin
            if (!rsp_valid_ff) begin
               rsp_in.used_mask  = mask_ff;
               rsp_in.used_count = 4'($countones(mask_ff));
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff == S_INIT && init_ptr_ff == '1) begin
         if (init_layers_ff == 4'd0) begin
            present_in = 4'd1;
         end else if (init_layers_ff > 4'(lmbs_pkg::MaxLayers)) begin
            present_in = 4'(lmbs_pkg::MaxLayers);
         end else begin
            present_in = init_layers_ff;
         end
         mask_in = 8'((9'd1 << present_in) - 9'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         init_ptr_ff    <= '0;
         node_count_ff  <= 11'd1024;
         init_layers_ff <= 4'd1;
         mask_ff        <= 8'd1;
         present_ff     <= 4'd1;
         rsp_valid_ff   <= 1'b0;
         wcnt_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         init_ptr_ff    <= init_ptr_in;
         node_count_ff  <= node_count_in;
         init_layers_ff <= init_layers_in;
         mask_ff        <= mask_in;
         present_ff     <= present_in;
         rsp_valid_ff   <= rsp_valid_in;
         wcnt_ff        <= wcnt_in;
      end
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      tgt_ff      <= tgt_in;
      count_ff    <= count_in;
      src_word_ff <= src_word_in;
   end

   // A request waits while the previous response is still held on rsp_.
   assign req_ready = (state_ff == S_IDLE) && !csr_valid && !rsp_valid_ff;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_mask_present: assert property (@(posedge clock) disable iff (reset)
      (mask_ff & ~present_mask) == 8'd0)
      else $error("allocated layer not present");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response not raised");

endmodule

// ===== hw/rtl/lmbs_ram.sv =====
module lmbs_ram #(
   parameter int Width = 64,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== tb/layered_mark_bitmap_store_tb.sv =====
module layered_mark_bitmap_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmbs_pkg::*;

   localparam int MaxMismatchPrints = 10;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   req_type  req_data;
   logic     rsp_valid;
   logic     rsp_ready;
   rsp_type  rsp_data;
   logic     csr_valid;
   logic     csr_ready;
   logic [0:0]  csr_index;
   logic [10:0] csr_data;

   layered_mark_bitmap_store dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the store. Marks are kept one bit per node and layer.
   logic [MaxNodes-1:0] shadow_marks [MaxLayers];
   logic [7:0]  shadow_alloc;
   int          shadow_present;
   logic [10:0] shadow_node_count;
   logic [3:0]  shadow_init_layers;

   req_type pending_cmds [$];
   rsp_type expected_rsps [$];

   int  mismatch_count;
   int  unexpected_count;
   bit  stim_done;
   bit  hold_rsp;    // Set while the receiver holds off for a long stretch.

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int effective_nodes();
      return (shadow_node_count > MaxNodes) ? MaxNodes : int'(shadow_node_count);
   endfunction

   function automatic logic [7:0] present_bits();
      return 8'((9'd1 << shadow_present) - 1);
   endfunction

   // Rebuilds the store the way a register write does.
   function automatic void init_store();
      int l;
      l = int'(shadow_init_layers);
      if (l < 1) l = 1;
      if (l > MaxLayers) l = MaxLayers;
      foreach (shadow_marks[i]) shadow_marks[i] = '0;
      shadow_present = l;
      shadow_alloc = present_bits();
   endfunction

   // Applies one command to the shadow store and returns the response it should give.
   function automatic rsp_type apply_cmd(req_type c);
      rsp_type r;
      logic [7:0] free_bits;
      bit lay_ok;
      bit node_ok;
      int n;
      r = '0;
      n = effective_nodes();
      lay_ok = int'(c.layer) < shadow_present;
      node_ok = int'(c.node) < n;
      case (c.cmd)
         CMD_QUERY, CMD_MARK, CMD_UNMARK, CMD_INVERT, CMD_CLEAR, CMD_COUNT: begin
            if (!lay_ok) begin
               r.status = ST_BAD_LAYER;
            end else begin
               case (c.cmd)
                  CMD_QUERY:  r.marked = node_ok && shadow_marks[c.layer][c.node];
                  CMD_MARK:   if (node_ok) shadow_marks[c.layer][c.node] = 1'b1;
                  CMD_UNMARK: if (node_ok) shadow_marks[c.layer][c.node] = 1'b0;
                  CMD_INVERT: begin
                     for (int i = 0; i < n; i++)
                        shadow_marks[c.layer][i] = ~shadow_marks[c.layer][i];
                  end
                  CMD_CLEAR:  shadow_marks[c.layer] = '0;
                  default:    r.mark_count = 11'($countones(shadow_marks[c.layer]));
               endcase
            end
         end
         CMD_ALLOC: begin
            free_bits = present_bits() & ~shadow_alloc;
            if (free_bits == 0) begin
               if (shadow_present >= MaxLayers) begin
                  r.status = ST_NO_FREE;
               end else begin
                  // Growing by one layer hands out a freshly cleared layer.
                  r.new_layer = 3'(shadow_present);
                  shadow_marks[shadow_present] = '0;
                  shadow_present++;
               end
            end else begin
               for (int i = MaxLayers - 1; i >= 0; i--)
                  if (free_bits[i]) r.new_layer = 3'(i);
            end
            if (r.status == ST_OK) shadow_alloc[r.new_layer] = 1'b1;
         end
         CMD_FREE: begin
            if (!lay_ok) begin
               r.status = ST_BAD_LAYER;
            end else if (!shadow_alloc[c.layer]) begin
               r.status = ST_NOT_ALLOC;
            end else begin
               shadow_marks[c.layer] = '0;
               shadow_alloc[c.layer] = 1'b0;
            end
         end
         CMD_MERGE: begin
            if (!lay_ok || int'(c.src_layer) >= shadow_present)
               r.status = ST_BAD_LAYER;
            else
               shadow_marks[c.layer] = shadow_marks[c.layer] | shadow_marks[c.src_layer];
         end
         CMD_WUSED: shadow_alloc = c.used_mask_in & present_bits();
         default: ;
      endcase
      r.used_mask = shadow_alloc;
      r.used_count = 4'($countones(shadow_alloc));
      return r;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Sender: presents queued commands, keeping valid and payload steady until accepted.
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && !req_ready) begin
         // Hold the current transaction.
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_cmds.size() > 0) begin
         req_valid <= 1'b1;
         req_data <= pending_cmds.pop_front();
         req_gap <= gap_length();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Prediction runs at acceptance so the shadow state follows the block's order.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(apply_cmd(req_data));
   end

   // Receiver: random back-pressure, plus the long hold-off when requested.
   int rsp_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid) rsp_gap <= gap_length();
      end
   end

   // Checks each response transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= MaxMismatchPrints)
               $display("Unexpected response %h", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= MaxMismatchPrints)
                  $display("Mismatch: expected st=%0d mk=%0d nl=%0d cnt=%0d um=%h uc=%0d, got st=%0d mk=%0d nl=%0d cnt=%0d um=%h uc=%0d",
                     want.status, want.marked, want.new_layer, want.mark_count,
                     want.used_mask, want.used_count, rsp_data.status,
                     rsp_data.marked, rsp_data.new_layer, rsp_data.mark_count,
                     rsp_data.used_mask, rsp_data.used_count);
            end
         end
      end
   end

   function automatic req_type make_cmd(logic [3:0] c, int node, int layer, int src, int msk);
      req_type r;
      r.cmd = c;
      r.node = 10'(node);
      r.layer = 3'(layer);
      r.src_layer = 3'(src);
      r.used_mask_in = 8'(msk);
      return r;
   endfunction

   // Mostly valid layers and in-range nodes, with some out-of-range noise.
   function automatic req_type random_cmd();
      req_type r;
      int p;
      r = req_type'($urandom);
      p = $urandom_range(99);
      if (p < 22) r.cmd = CMD_MARK;
      else if (p < 34) r.cmd = CMD_QUERY;
      else if (p < 40) r.cmd = CMD_UNMARK;
      else if (p < 46) r.cmd = CMD_INVERT;
      else if (p < 56) r.cmd = CMD_ALLOC;
      else if (p < 63) r.cmd = CMD_FREE;
      else if (p < 67) r.cmd = CMD_CLEAR;
      else if (p < 75) r.cmd = CMD_COUNT;
      else if (p < 83) r.cmd = CMD_MERGE;
      else if (p < 87) r.cmd = CMD_UCOUNT;
      else if (p < 92) r.cmd = CMD_WUSED;
      else r.cmd = 4'($urandom_range(15, 11));
      if ($urandom_range(9) < 8) begin
         r.layer = 3'($urandom_range(shadow_present - 1));
         r.src_layer = 3'($urandom_range(shadow_present - 1));
      end
      if (effective_nodes() > 0 && $urandom_range(9) < 8)
         r.node = 10'($urandom_range(effective_nodes() - 1));
      return r;
   endfunction

   // Sends one register write once the block is idle and its queue is drained.
   task automatic write_reg(logic [0:0] idx, logic [10:0] value);
      wait (pending_cmds.size() == 0 && expected_rsps.size() == 0 && !req_valid);
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_NODE_COUNT) shadow_node_count = value;
      else shadow_init_layers = value[3:0];
      init_store();
   endtask

   // Random commands are generated one at a time so the layer picks follow the
   // shadow state closely enough to stay mostly legal.
   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         wait (pending_cmds.size() < 2);
         pending_cmds.push_back(random_cmd());
         @(posedge clock);
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_NODE_COUNT;
      csr_data = '0;
      hold_rsp = 1'b0;
      stim_done = 1'b0;
      mismatch_count = 0;
      unexpected_count = 0;
      shadow_node_count = 11'd1024;
      shadow_init_layers = 4'd1;
      init_store();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of nodes, each command but unmark, and the error cases.
      pending_cmds.push_back(make_cmd(CMD_MARK, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_MARK, 1023, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 1023, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 5, 7, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_FREE, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_FREE, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_MARK, 64, 0, 0, 0));
      for (int i = 0; i < 8; i++)
         pending_cmds.push_back(make_cmd(CMD_ALLOC, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_MERGE, 0, 7, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_MERGE, 0, 1, 7, 0));
      pending_cmds.push_back(make_cmd(CMD_INVERT, 0, 7, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_COUNT, 0, 7, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_WUSED, 0, 0, 0, 8'hA5));
      pending_cmds.push_back(make_cmd(CMD_UCOUNT, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 7, 0, 0));
      pending_cmds.push_back(make_cmd(4'd15, 1023, 7, 7, 8'hFF));
      wait (pending_cmds.size() == 0);

      // Long receiver hold-off while the sender keeps offering transactions.
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++)
         pending_cmds.push_back(make_cmd(CMD_MARK, i * 3, 2, 0, 0));
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
      run_random(150);

      // Small node count with one layer: out-of-range nodes and partial invert.
      write_reg(CSR_NODE_COUNT, 11'd1);
      write_reg(CSR_INIT_LAYERS, 4'd1);
      pending_cmds.push_back(make_cmd(CMD_INVERT, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_MARK, 1, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_COUNT, 0, 0, 0, 0));
      run_random(100);

      write_reg(CSR_NODE_COUNT, 11'd0);
      write_reg(CSR_INIT_LAYERS, 4'd8);
      run_random(80);

      write_reg(CSR_NODE_COUNT, 11'd2047);
      write_reg(CSR_INIT_LAYERS, 4'd0);
      run_random(120);

      write_reg(CSR_NODE_COUNT, 11'($urandom_range(1000, 65)));
      write_reg(CSR_INIT_LAYERS, 4'd15);
      run_random(120);

      write_reg(CSR_NODE_COUNT, 11'd1024);
      write_reg(CSR_INIT_LAYERS, 4'd3);
      run_random(100);

      wait (pending_cmds.size() == 0 && !req_valid);
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      wait (expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && unexpected_count == 0 && expected_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
